// ===== rtl/drc_pkg.sv =====
package drc_pkg;

    localparam int COORD_W = 16;
    localparam int IDX_W   = 6;
    localparam int RANK_W  = 6;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [IDX_W-1:0]   idx;
        logic [RANK_W-1:0]  cnt;
    } token_t;

endpackage

// ===== rtl/drc_cell.sv =====
module drc_cell
    import drc_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  token_t            tok_in,
    output token_t            tok_out,
    input  logic              shift,
    input  logic [RANK_W-1:0] rank_in,
    output logic [RANK_W-1:0] rank_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    token_t             tok_reg;
    token_t             tok_next;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] x_next;
    logic [COORD_W-1:0] y_reg;
    logic [COORD_W-1:0] y_next;
    logic [RANK_W-1:0]  rank_reg;
    logic [RANK_W-1:0]  rank_next;

    logic here;
    logic past;
    logic tok_dom_cell;
    logic cell_dom_tok;

    always_comb
    begin
        here = tok_in.valid && (tok_in.idx == MY_IDX);
        past = tok_in.valid && (tok_in.idx > MY_IDX);

        tok_dom_cell = (x_reg <= tok_in.x) && (y_reg <= tok_in.y);
        cell_dom_tok = (tok_in.x <= x_reg) && (tok_in.y <= y_reg)
                       && !((tok_in.x == x_reg) && (tok_in.y == y_reg));

        tok_next       = tok_in;
        tok_next.valid = past;
        tok_next.cnt   = tok_in.cnt + RANK_W'(past && tok_dom_cell);

        x_next = here ? tok_in.x : x_reg;
        y_next = here ? tok_in.y : y_reg;

        priority if (shift)
        begin
            rank_next = rank_in;
        end
        else if (here)
        begin
            rank_next = tok_in.cnt;
        end
        else if (past && cell_dom_tok)
        begin
            rank_next = rank_reg + RANK_W'(1);
        end
        else
        begin
            rank_next = rank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        rank_reg <= rank_next;
    end

    assign tok_out  = tok_reg;
    assign rank_out = rank_reg;

endmodule

// ===== rtl/dominance_rank_counter.sv =====
// Ranks are drained only after the last point of a set is taken and the sequencer has left S_WAIT.
// Throughput: one point per cycle while loading; ranks drain one per cycle while the output is
// free of back-pressure. A set passes through the load, the token run through the cell chain
// and the serial drain of the rank chain through cell 0; no new point is taken until the drain ends.
// Reset: asynchronous, active low; clears the point count, the sequencer and all valids.
module dominance_rank_counter
    import drc_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                point_valid,
    output logic                point_ready,
    input  logic [COORD_W-1:0]  x_coord,
    input  logic [COORD_W-1:0]  y_coord,
    input  logic                last_point,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [IDX_W-1:0]    point_index,
    output logic [RANK_W-1:0]   rank,
    output logic                last_result
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [COORD_W-1:0] COORD_MASK =
        (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}}
                                : COORD_W'((64'd1 << COORD_BITS) - 64'd1);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  loaded_count_reg;
    logic [CNT_W-1:0]  loaded_count_next;
    logic [CNT_W-1:0]  wait_reg;
    logic [CNT_W-1:0]  wait_next;
    logic [CNT_W-1:0]  emit_idx_reg;
    logic [CNT_W-1:0]  emit_idx_next;
    token_t            inj_reg;
    token_t            inj_next;

    logic              result_valid_reg;
    logic              result_valid_next;
    logic [IDX_W-1:0]  point_index_reg;
    logic [IDX_W-1:0]  point_index_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;
    logic              last_result_reg;
    logic              last_result_next;

    logic              accept;
    logic              has_room;
    logic [CNT_W-1:0]  count_after;
    logic              out_free;
    logic              emit_go;
    logic              emit_last;

    token_t            tok_chain  [0:MAX_POINTS];
    logic [RANK_W-1:0] rank_chain [0:MAX_POINTS-1];
    logic [RANK_W-1:0] shift_in   [0:MAX_POINTS-1];

    assign tok_chain[0] = inj_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++)
        begin : g_cell
            if (gi == MAX_POINTS - 1)
            begin : g_end
                assign shift_in[gi] = '0;
            end
            else
            begin : g_mid
                assign shift_in[gi] = rank_chain[gi+1];
            end

            drc_cell #(
                .CELL_IDX (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .tok_in   (tok_chain[gi]),
                .tok_out  (tok_chain[gi+1]),
                .shift    (emit_go),
                .rank_in  (shift_in[gi]),
                .rank_out (rank_chain[gi])
            );
        end
    endgenerate

    always_comb
    begin
        point_ready = (state_reg == S_LOAD);
        accept      = point_valid && point_ready;
        has_room    = loaded_count_reg < CNT_W'(MAX_POINTS);
        count_after = loaded_count_reg + CNT_W'(has_room);
        out_free    = !result_valid_reg || result_ready;
        emit_go     = (state_reg == S_EMIT) && out_free;
        emit_last   = (emit_idx_reg == (loaded_count_reg - CNT_W'(1)));

        inj_next       = '0;
        inj_next.valid = accept && has_room;
        inj_next.x     = x_coord & COORD_MASK;
        inj_next.y     = y_coord & COORD_MASK;
        inj_next.idx   = IDX_W'(loaded_count_reg);

        state_next        = state_reg;
        loaded_count_next = loaded_count_reg;
        wait_next         = wait_reg;
        emit_idx_next     = emit_idx_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    loaded_count_next = count_after;
                    if (last_point)
                    begin
                        state_next = S_WAIT;
                        wait_next  = count_after;
                    end
                end
            end
            S_WAIT:
            begin
                wait_next = wait_reg - CNT_W'(1);
                if (wait_reg == CNT_W'(1))
                begin
                    state_next    = S_EMIT;
                    emit_idx_next = '0;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit_idx_next = emit_idx_reg + CNT_W'(1);
                    if (emit_last)
                    begin
                        state_next        = S_LOAD;
                        loaded_count_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (emit_go)
        begin
            result_valid_next = 1'b1;
            point_index_next  = IDX_W'(emit_idx_reg);
            rank_next         = rank_chain[0];
            last_result_next  = emit_last;
        end
        else
        begin
            result_valid_next = result_valid_reg && !result_ready;
            point_index_next  = point_index_reg;
            rank_next         = rank_reg;
            last_result_next  = last_result_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            loaded_count_reg <= '0;
            wait_reg         <= '0;
            emit_idx_reg     <= '0;
            inj_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            loaded_count_reg <= loaded_count_next;
            wait_reg         <= wait_next;
            emit_idx_reg     <= emit_idx_next;
            inj_reg          <= inj_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        point_index_reg <= point_index_next;
        rank_reg        <= rank_next;
        last_result_reg <= last_result_next;
    end

    assign result_valid = result_valid_reg;
    assign point_index  = point_index_reg;
    assign rank         = rank_reg;
    assign last_result  = last_result_reg;

    a_no_token_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !tok_chain[MAX_POINTS].valid)
        else $error("token ran past the last cell");

    a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && point_ready && last_point) |=> !point_ready)
        else $error("point taken after the set closed");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (emit_idx_reg < loaded_count_reg))
        else $error("drain index beyond stored points");

    a_more_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !last_result) |-> (state_reg == S_EMIT))
        else $error("non-final rank delivered outside the drain");

endmodule

// ===== bench/tb_dominance_rank_counter.sv =====
module tb_dominance_rank_counter;
    import drc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS   = 64;
    localparam int N_DIR     = 20;
    localparam int N_ITEMS   = 200;
    localparam int QUIET_AT  = 170;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
        logic               pinned;
        logic [RANK_W-1:0]  rank;
    } stim_row_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [RANK_W-1:0] rank;
        logic              last;
    } rank_item_t;

    logic               clk;
    logic               rst_n;
    logic               point_valid;
    logic               point_ready;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic               last_point;
    logic               result_valid;
    logic               result_ready;
    logic [IDX_W-1:0]   point_index;
    logic [RANK_W-1:0]  rank;
    logic               last_result;

    logic               cur_pinned;
    logic [RANK_W-1:0]  cur_pin_rank;
    logic               gaps_on;

    stim_row_t          dir_rows [N_DIR];
    rank_item_t         pending_ranks [$];

    logic [COORD_W-1:0] set_x [MAX_PTS];
    logic [COORD_W-1:0] set_y [MAX_PTS];
    logic               set_pinned [MAX_PTS];
    logic [RANK_W-1:0]  set_pin_rank [MAX_PTS];
    int                 set_count;

    int                 errors;
    int                 items_sent;
    int                 sets_closed;
    int                 points_dropped;
    int                 ranks_checked;
    int                 stall_left;

    dominance_rank_counter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .last_point   (last_point),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .point_index  (point_index),
        .rank         (rank),
        .last_result  (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("dominance_rank_counter: mismatch");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // count earlier points in (x, y, arrival) order whose y does not exceed this one
    function automatic logic [RANK_W-1:0] dominance_of(input int p, input int n);
        int cnt;
        logic ahead;
        cnt = 0;
        for (int q = 0; q < n; q++)
        begin
            if (set_x[q] != set_x[p])
                ahead = set_x[q] < set_x[p];
            else if (set_y[q] != set_y[p])
                ahead = set_y[q] < set_y[p];
            else
                ahead = q < p;
            if (q != p && set_y[q] <= set_y[p] && ahead)
                cnt++;
        end
        return cnt[RANK_W-1:0];
    endfunction

    task automatic take_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic lst, input logic pin, input logic [RANK_W-1:0] pr);
        rank_item_t it;
        if (set_count < MAX_PTS)
        begin
            set_x[set_count]        = x;
            set_y[set_count]        = y;
            set_pinned[set_count]   = pin;
            set_pin_rank[set_count] = pr;
            set_count++;
        end
        else
            points_dropped++;
        if (lst)
        begin
            for (int p = 0; p < set_count; p++)
            begin
                it.idx  = p[IDX_W-1:0];
                it.rank = set_pinned[p] ? set_pin_rank[p] : dominance_of(p, set_count);
                it.last = (p == set_count - 1);
                pending_ranks.push_back(it);
            end
            set_count = 0;
            sets_closed++;
        end
    endtask

    task automatic check_rank();
        rank_item_t want;
        if (pending_ranks.size() == 0)
        begin
            note_mismatch($sformatf("unexpected rank: idx %0d rank %0d last %0d",
                                    point_index, rank, last_result));
            return;
        end
        want = pending_ranks.pop_front();
        ranks_checked++;
        if (point_index !== want.idx || rank !== want.rank || last_result !== want.last)
            note_mismatch($sformatf("expected idx %0d rank %0d last %0d, got idx %0d rank %0d last %0d",
                                    want.idx, want.rank, want.last,
                                    point_index, rank, last_result));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (point_valid && point_ready)
                take_point(x_coord, y_coord, last_point, cur_pinned, cur_pin_rank);
            if (result_valid && result_ready)
                check_rank();
        end
    end

    // receiver: bursts of backpressure while gaps are enabled
    initial
    begin
        result_ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 5);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic lst, input logic pin, input logic [RANK_W-1:0] pr);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            point_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        point_valid  <= 1'b1;
        x_coord      <= x;
        y_coord      <= y;
        last_point   <= lst;
        cur_pinned   <= pin;
        cur_pin_rank <= pr;
        do
            @(posedge clk);
        while (!(point_valid && point_ready));
        items_sent++;
        if (items_sent >= QUIET_AT)
            gaps_on = 1'b0;
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        point_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_ranks.size() != 0);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(input int mode);
        case (mode)
            0:       return COORD_W'($urandom_range(0, 3));
            1:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default:
                if ($urandom_range(0, 5) == 0)
                    return ($urandom_range(0, 1) != 0) ? '1 : '0;
                else
                    return COORD_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int set_no;
        int n;
        int mode;
        int wait_cnt;

        rst_n        = 1'b0;
        point_valid  = 1'b0;
        x_coord      = '0;
        y_coord      = '0;
        last_point   = 1'b0;
        cur_pinned   = 1'b0;
        cur_pin_rank = '0;
        gaps_on      = 1'b1;
        set_count    = 0;
        errors       = 0;
        items_sent   = 0;
        sets_closed  = 0;
        points_dropped = 0;
        ranks_checked  = 0;

        dir_rows = '{
            '{16'h0000, 16'h0000, 1'b1, 1'b1, 6'd0},
            '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 6'd0},
            '{16'h0000, 16'h0000, 1'b0, 1'b1, 6'd0},
            '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 6'd1},
            '{16'hFFFF, 16'h0000, 1'b0, 1'b1, 6'd0},
            '{16'h0000, 16'hFFFF, 1'b1, 1'b1, 6'd0},
            '{16'h0005, 16'h0005, 1'b0, 1'b1, 6'd0},
            '{16'h0005, 16'h0005, 1'b0, 1'b1, 6'd1},
            '{16'h0005, 16'h0005, 1'b1, 1'b1, 6'd2},
            '{16'h0007, 16'h0009, 1'b0, 1'b1, 6'd1},
            '{16'h0007, 16'h0003, 1'b1, 1'b1, 6'd0},
            '{16'h0009, 16'h0004, 1'b0, 1'b1, 6'd1},
            '{16'h0002, 16'h0004, 1'b1, 1'b1, 6'd0},
            '{16'd100,  16'd200,  1'b0, 1'b0, 6'd0},
            '{16'd50,   16'd300,  1'b0, 1'b0, 6'd0},
            '{16'd300,  16'd50,   1'b0, 1'b0, 6'd0},
            '{16'd150,  16'd150,  1'b0, 1'b0, 6'd0},
            '{16'd100,  16'd200,  1'b1, 1'b0, 6'd0},
            '{16'h5555, 16'hAAAA, 1'b0, 1'b0, 6'd0},
            '{16'hAAAA, 16'h5555, 1'b1, 1'b0, 6'd0}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last,
                       dir_rows[i].pinned, dir_rows[i].rank);

        hold_until_drained();

        set_no = 0;
        while (items_sent < N_ITEMS)
        begin
            if (set_no == 3)
            begin
                // past capacity: ranks climb to the top, extra points dropped
                for (int k = 0; k < MAX_PTS + 6; k++)
                begin
                    if (k < MAX_PTS)
                        send_point(COORD_W'(k * 1000 + $urandom_range(0, 999)),
                                   COORD_W'(k * 1000 + $urandom_range(0, 999)),
                                   1'b0, 1'b0, '0);
                    else
                        send_point(COORD_W'($urandom), COORD_W'($urandom),
                                   k == MAX_PTS + 5, 1'b0, '0);
                end
            end
            else
            begin
                if (set_no == 5)
                    hold_until_drained();
                n    = (set_no == 6) ? MAX_PTS : $urandom_range(1, 10);
                mode = $urandom_range(0, 3);
                for (int k = 0; k < n; k++)
                    send_point(pick_coord(mode), pick_coord(mode), k == n - 1, 1'b0, '0);
            end
            set_no++;
        end
        point_valid <= 1'b0;

        wait_cnt = 0;
        while (pending_ranks.size() != 0 && wait_cnt < 20000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (200) @(posedge clk);
        if (pending_ranks.size() != 0)
            note_mismatch($sformatf("%0d ranks never arrived", pending_ranks.size()));

        $display("covered %0d points in %0d sets, %0d dropped past capacity", items_sent,
                 sets_closed, points_dropped);
        $display("checked %0d ranks, %0d mismatches", ranks_checked, errors);
        if (errors == 0)
            $display("dominance_rank_counter: match");
        else
            $display("dominance_rank_counter: mismatch");
        $finish;
    end

endmodule
